// File: sv/rpmc_pkg.sv
`default_nettype none
package rpmc_pkg;

  // Image geometry and field widths
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 10;
  localparam int CNT_W    = 21;
  localparam int SUM_W    = 30;
  localparam int QUOT_W   = COORD_W;
  localparam int DSH_W    = CNT_W + QUOT_W - 1;
  localparam int STEP_W   = $clog2(QUOT_W);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_RED_THRESHOLD = 1'b0;

  // Decoupling queue
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Limits
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [PIX_W-1:0]   PIX_FULL  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0]   PIX_ZERO  = {PIX_W{1'b0}};
  localparam int                 FIELD_MAX = (1 << COORD_W) - 1;
  localparam logic [COORD_W-1:0] COL_CAP   = (MAX_COLS - 1 < FIELD_MAX) ?
                                             COORD_W'(MAX_COLS - 1) : COORD_W'(FIELD_MAX);
  localparam logic [COORD_W-1:0] ROW_CAP   = (MAX_ROWS - 1 < FIELD_MAX) ?
                                             COORD_W'(MAX_ROWS - 1) : COORD_W'(FIELD_MAX);

  typedef struct packed {
    logic [PIX_W-1:0]   blue_in;
    logic [PIX_W-1:0]   green_in;
    logic [PIX_W-1:0]   red_in;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_pos;
    logic               frame_last;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   blue_out;
    logic [PIX_W-1:0]   green_out;
    logic [PIX_W-1:0]   red_out;
    logic               is_red;
    logic               frame_done;
    logic [CNT_W-1:0]   red_count;
    logic [COORD_W-1:0] column_mean;
    logic [COORD_W-1:0] row_mean;
    logic               mean_valid;
  } pix_out_t;

  // Classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    logic               hit;
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } q_entry_t;

endpackage
`default_nettype wire

// File: sv/red_pixel_mask_centroid.sv
`default_nettype none
// Red pixel mask and centroid. Each accepted pixel gives exactly one result: red pixels
// (floor(red/(blue+green+2)) above red_threshold) come out as pure blue, others unchanged,
// and the pixel marked frame_last also carries the frame's red count and the truncated
// mean column and row of its red pixels. A classifier front end feeds a two-entry queue;
// the back end accumulates and owns the result register. Ordinary pixels flow at one per
// clock while the output is not stalled. The last pixel of a frame occupies the back end
// for the pop, a one-bit-per-cycle restoring division of the column and row sums (run in
// parallel on one shifted divisor), then the result load; the queue keeps accepting until
// it fills. Write red_threshold only while the block is idle.
module red_pixel_mask_centroid (
  input  var logic                                clk,
  input  var logic                                rst_n,
  input  var logic                                in_valid,
  output logic                                    in_ready,
  input  var rpmc_pkg::pix_in_t                   in_data,
  output logic                                    out_valid,
  input  var logic                                out_ready,
  output rpmc_pkg::pix_out_t                      out_data,
  input  var logic                                psel,
  input  var logic                                penable,
  input  var logic                                pwrite,
  input  var logic [rpmc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  var logic [rpmc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rpmc_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                    pready
);
  import rpmc_pkg::*;

  logic [PIX_W-1:0] thr_r;
  q_entry_t         f_entry, q_entry;
  logic             q_full, q_valid, q_pop, push;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RED_THRESHOLD) ?
                  {{(CFG_DATA_W-PIX_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RED_THRESHOLD) begin
      thr_r <= pwdata[PIX_W-1:0];
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  rpmc_front u_front (
    .pix_i       (in_data),
    .threshold_i (thr_r),
    .entry_o     (f_entry)
  );

  rpmc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_entry)
  );

  rpmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

endmodule
`default_nettype wire

// File: sv/rpmc_front.sv
`default_nettype none
module rpmc_front (
  input  var rpmc_pkg::pix_in_t             pix_i,
  input  var logic [rpmc_pkg::PIX_W-1:0]    threshold_i,
  output rpmc_pkg::q_entry_t                entry_o
);
  import rpmc_pkg::*;

  logic [PIX_W:0]      thr_p1;
  logic [PIX_W+1:0]    den;
  logic [2*PIX_W+2:0]  prod;
  logic                hit;

  // floor(r/d) > t  <=>  r >= (t+1)*d
  assign thr_p1 = {1'b0, threshold_i} + {{PIX_W{1'b0}}, 1'b1};
  assign den    = {2'b00, pix_i.blue_in} + {2'b00, pix_i.green_in} + (PIX_W+2)'(2);
  assign prod   = thr_p1 * den;
  assign hit    = {{(PIX_W+3){1'b0}}, pix_i.red_in} >= prod;

  // Classified entry, coordinates clamped to the image
  always_comb begin
    entry_o.blue  = pix_i.blue_in;
    entry_o.green = pix_i.green_in;
    entry_o.red   = pix_i.red_in;
    entry_o.hit   = hit;
    entry_o.last  = pix_i.frame_last;
    entry_o.col   = (32'(pix_i.column) >= 32'(MAX_COLS)) ?
                    COORD_W'(MAX_COLS - 1) : pix_i.column;
    entry_o.row   = (32'(pix_i.row_pos) >= 32'(MAX_ROWS)) ?
                    COORD_W'(MAX_ROWS - 1) : pix_i.row_pos;
  end

endmodule
`default_nettype wire

// File: sv/rpmc_fifo.sv
`default_nettype none
module rpmc_fifo (
  input  var logic               clk,
  input  var logic               rst_n,
  input  var logic               push_i,
  input  var rpmc_pkg::q_entry_t wdata_i,
  output logic                   full_o,
  input  var logic               pop_i,
  output logic                   valid_o,
  output rpmc_pkg::q_entry_t     rdata_o
);
  import rpmc_pkg::*;

  q_entry_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   fill_r;

  assign full_o  = fill_r == (PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = fill_r != '0;
  assign rdata_o = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/rpmc_back.sv
`default_nettype none
module rpmc_back (
  input  var logic               clk,
  input  var logic               rst_n,
  input  var logic               q_valid_i,
  input  var rpmc_pkg::q_entry_t q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  var logic               out_ready_i,
  output rpmc_pkg::pix_out_t     out_data_o
);
  import rpmc_pkg::*;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              out_valid_r;
  pix_out_t          out_data_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  csum_r, rsum_r;

  // Divider and held last pixel
  q_entry_t          hold_r;
  logic [CNT_W-1:0]  fcnt_r;
  logic [SUM_W-1:0]  crem_r, rrem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [QUOT_W-1:0] cq_r, rq_r;
  logic              covf_r, rovf_r;
  logic [STEP_W-1:0] step_r;

  logic              out_free, pop;
  logic [CNT_W-1:0]  cnt_add;
  logic [SUM_W:0]    csum_wide, rsum_wide;
  logic [SUM_W-1:0]  csum_add, rsum_add;
  logic              c_ge, r_ge;
  logic [COORD_W-1:0] cmean, rmean;
  pix_out_t          pix_res, fin_res;

  assign out_free    = !out_valid_r || out_ready_i;
  assign pop         = (state_r == ST_RUN) && q_valid_i && out_free;
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  // Saturating accumulate of the popped pixel
  assign cnt_add   = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign csum_wide = {1'b0, csum_r} + {{(SUM_W+1-COORD_W){1'b0}}, q_entry_i.col};
  assign rsum_wide = {1'b0, rsum_r} + {{(SUM_W+1-COORD_W){1'b0}}, q_entry_i.row};
  assign csum_add  = csum_wide[SUM_W] ? SUM_MAX : csum_wide[SUM_W-1:0];
  assign rsum_add  = rsum_wide[SUM_W] ? SUM_MAX : rsum_wide[SUM_W-1:0];

  // Restoring divider compare, one quotient bit per cycle
  assign c_ge = crem_r >= dsh_r;
  assign r_ge = rrem_r >= dsh_r;

  // Pixel part of a result
  always_comb begin
    pix_res = '0;
    pix_res.blue_out  = q_entry_i.hit ? PIX_FULL : q_entry_i.blue;
    pix_res.green_out = q_entry_i.hit ? PIX_ZERO : q_entry_i.green;
    pix_res.red_out   = q_entry_i.hit ? PIX_ZERO : q_entry_i.red;
    pix_res.is_red    = q_entry_i.hit;
  end

  // Frame statistics from the finished division
  always_comb begin
    cmean = (covf_r || cq_r > COL_CAP) ? COL_CAP : cq_r;
    rmean = (rovf_r || rq_r > ROW_CAP) ? ROW_CAP : rq_r;
    fin_res = '0;
    fin_res.blue_out    = hold_r.hit ? PIX_FULL : hold_r.blue;
    fin_res.green_out   = hold_r.hit ? PIX_ZERO : hold_r.green;
    fin_res.red_out     = hold_r.hit ? PIX_ZERO : hold_r.red;
    fin_res.is_red      = hold_r.hit;
    fin_res.frame_done  = 1'b1;
    fin_res.red_count   = fcnt_r;
    if (fcnt_r != '0) begin
      fin_res.column_mean = cmean;
      fin_res.row_mean    = rmean;
      fin_res.mean_valid  = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (pop && q_entry_i.last) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Control state: sequencer, accumulators, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      csum_r      <= '0;
      rsum_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop && !q_entry_i.last) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (q_entry_i.last) begin
          cnt_r  <= '0;
          csum_r <= '0;
          rsum_r <= '0;
        end else if (q_entry_i.hit) begin
          cnt_r  <= cnt_add;
          csum_r <= csum_add;
          rsum_r <= rsum_add;
        end
      end
    end
  end

  // Datapath: result register and divider
  always_ff @(posedge clk) begin
    if (pop && !q_entry_i.last) begin
      out_data_r <= pix_res;
    end else if (state_r == ST_FIN && out_free) begin
      out_data_r <= fin_res;
    end

    if (pop && q_entry_i.last) begin
      hold_r <= q_entry_i;
      fcnt_r <= q_entry_i.hit ? cnt_add : cnt_r;
      crem_r <= q_entry_i.hit ? csum_add : csum_r;
      rrem_r <= q_entry_i.hit ? rsum_add : rsum_r;
      dsh_r  <= {(q_entry_i.hit ? cnt_add : cnt_r), {(QUOT_W-1){1'b0}}};
      covf_r <= {1'b0, (q_entry_i.hit ? csum_add : csum_r)} >=
                {(q_entry_i.hit ? cnt_add : cnt_r), {QUOT_W{1'b0}}};
      rovf_r <= {1'b0, (q_entry_i.hit ? rsum_add : rsum_r)} >=
                {(q_entry_i.hit ? cnt_add : cnt_r), {QUOT_W{1'b0}}};
      step_r <= STEP_W'(QUOT_W - 1);
    end else if (state_r == ST_DIV) begin
      cq_r   <= {cq_r[QUOT_W-2:0], c_ge};
      rq_r   <= {rq_r[QUOT_W-2:0], r_ge};
      crem_r <= c_ge ? crem_r - dsh_r : crem_r;
      rrem_r <= r_ge ? rrem_r - dsh_r : rrem_r;
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/rpmc_checker.sv
`default_nettype none
module rpmc_checker (
  input var logic                clk,
  input var logic                rst_n,
  input var logic                out_valid,
  input var logic                out_ready,
  input var rpmc_pkg::pix_out_t  out_data
);
  import rpmc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Statistics only on the last pixel of a frame
  a_stats_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_done |->
      out_data.red_count == '0 && !out_data.mean_valid &&
      out_data.column_mean == '0 && out_data.row_mean == '0)
    else $error("frame statistics on a non-final item");

  // Means valid only with a nonzero count
  a_mean_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.mean_valid == (out_data.red_count != '0))
    else $error("mean_valid disagrees with red_count");

  // Red pixels are masked to pure blue
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_red |->
      out_data.blue_out == PIX_FULL && out_data.green_out == PIX_ZERO &&
      out_data.red_out == PIX_ZERO)
    else $error("red pixel not masked");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind red_pixel_mask_centroid rpmc_checker u_rpmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rpmc_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int BACKEND_BUSY  = 12;   // last pixel holds the back end this long
  localparam int UNUSED_REG    = 1;    // register index with nothing behind it
  localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = CFG_ADDR_W'(4 * REG_RED_THRESHOLD);
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR    = CFG_ADDR_W'(4 * UNUSED_REG);
  localparam int HOLD_CYCLES   = 150;
  localparam int HOLD_AT_A     = 200;
  localparam int HOLD_AT_B     = 520;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  pix_in_t   in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pix_out_t  out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  red_pixel_mask_centroid u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Pixel queue, expected results and the mirrored block state
  pix_in_t          pixel_queue[$];
  pix_out_t         expected_pixels[$];
  logic [7:0]       threshold_model = '0;
  logic [CNT_W-1:0] red_hits  = '0;
  logic [SUM_W-1:0] col_total = '0;
  logic [SUM_W-1:0] row_total = '0;
  int               mismatch_count = 0;
  int               gap_pct   = 12;
  int               stall_pct = 12;
  int               results_seen = 0;
  int               hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Mean of a coordinate sum, capped to the image edge and the field range
  function automatic logic [COORD_W-1:0] capped_mean(logic [SUM_W-1:0] sum,
                                                     logic [CNT_W-1:0] cnt, int limit);
    logic [SUM_W-1:0] q;
    if (cnt == 0) return '0;
    q = sum / cnt;
    if (q > limit - 1) q = SUM_W'(limit - 1);
    if (q > 1023) q = SUM_W'(1023);
    return q[COORD_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] sum,
                                               logic [COORD_W-1:0] add);
    logic [SUM_W:0] wide;
    wide = sum + add;
    return (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
  endfunction

  // Classify one pixel, mask it, and fold it into the frame statistics
  function automatic pix_out_t mask_and_accumulate(pix_in_t px);
    pix_out_t         res;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int unsigned      ratio;
    bit               hit;
    res   = '0;
    col   = (px.column >= MAX_COLS) ? COORD_W'(MAX_COLS - 1) : px.column;
    row   = (px.row_pos >= MAX_ROWS) ? COORD_W'(MAX_ROWS - 1) : px.row_pos;
    ratio = 32'(px.red_in) / (32'(px.blue_in) + 32'(px.green_in) + 2);
    hit   = ratio > threshold_model;
    if (hit) begin
      if (red_hits != CNT_MAX) red_hits = red_hits + 1'b1;
      col_total = sat_sum(col_total, col);
      row_total = sat_sum(row_total, row);
      res.blue_out  = 8'd255;
      res.green_out = 8'd0;
      res.red_out   = 8'd0;
    end else begin
      res.blue_out  = px.blue_in;
      res.green_out = px.green_in;
      res.red_out   = px.red_in;
    end
    res.is_red     = hit;
    res.frame_done = px.frame_last;
    if (px.frame_last) begin
      res.red_count   = red_hits;
      res.column_mean = capped_mean(col_total, red_hits, MAX_COLS);
      res.row_mean    = capped_mean(row_total, red_hits, MAX_ROWS);
      res.mean_valid  = (red_hits != 0);
      red_hits  = '0;
      col_total = '0;
      row_total = '0;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Driver: offers queued pixels, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(mask_and_accumulate(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no pixel pending");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("blue_out",    32'(want.blue_out),    32'(out_data.blue_out));
          check_field("green_out",   32'(want.green_out),   32'(out_data.green_out));
          check_field("red_out",     32'(want.red_out),     32'(out_data.red_out));
          check_field("is_red",      32'(want.is_red),      32'(out_data.is_red));
          check_field("frame_done",  32'(want.frame_done),  32'(out_data.frame_done));
          check_field("red_count",   32'(want.red_count),   32'(out_data.red_count));
          check_field("column_mean", 32'(want.column_mean), 32'(out_data.column_mean));
          check_field("row_mean",    32'(want.row_mean),    32'(out_data.row_mean));
          check_field("mean_valid",  32'(want.mean_valid),  32'(out_data.mean_valid));
        end
        results_seen++;
        // long back-pressure so the input side fills up and stalls
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic pix_in_t make_pixel(int b, int g, int r, int col, int row, int is_last);
    pix_in_t px;
    px.blue_in    = PIX_W'(b);
    px.green_in   = PIX_W'(g);
    px.red_in     = PIX_W'(r);
    px.column     = COORD_W'(col);
    px.row_pos    = COORD_W'(row);
    px.frame_last = (is_last != 0);
    return px;
  endfunction

  function automatic int random_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // Mix of plain noise, strongly red pixels, near-threshold and extreme channels
  function automatic pix_in_t random_pixel(bit is_last);
    int b, g, r;
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 255); g = $urandom_range(0, 255); r = $urandom_range(0, 255);
      end
      1: begin
        b = $urandom_range(0, 7); g = $urandom_range(0, 7); r = $urandom_range(128, 255);
      end
      2: begin
        b = $urandom_range(0, 31); g = $urandom_range(0, 31); r = $urandom_range(0, 255);
      end
      default: begin
        b = $urandom_range(0, 1) * 255; g = $urandom_range(0, 1) * 255;
        r = $urandom_range(0, 1) * 255;
      end
    endcase
    return make_pixel(b, g, r, random_coord(), random_coord(), int'(is_last));
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == THRESHOLD_ADDR) threshold_model = data[7:0];
  endtask

  // Wait until every queued pixel has produced its result
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (BACKEND_BUSY + 2) @(posedge clk);
  endtask

  // Random frames, each phase closed by a frame end
  task automatic random_frames(int count, int gap, int stall);
    int left, len;
    gap_pct   = gap;
    stall_pct = stall;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) pixel_queue.push_back(random_pixel(i == len - 1));
      left -= len;
    end
    drain();
  endtask

  // Stimulus sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold 0: boundaries of the ratio, coordinate extremes, empty frames
    write_reg(THRESHOLD_ADDR, 32'd0);
    pixel_queue.push_back(make_pixel(0, 0, 255, 0, 0, 0));
    pixel_queue.push_back(make_pixel(255, 255, 255, 1023, 1023, 0));
    pixel_queue.push_back(make_pixel(0, 0, 2, 1023, 0, 0));
    pixel_queue.push_back(make_pixel(0, 0, 1, 0, 1023, 0));
    pixel_queue.push_back(make_pixel(127, 126, 255, 512, 256, 1));
    pixel_queue.push_back(make_pixel(0, 0, 1, 5, 5, 1));
    pixel_queue.push_back(make_pixel(0, 0, 0, 0, 0, 1));
    for (int i = 0; i < 3; i++) pixel_queue.push_back(make_pixel(0, 0, 255, 1023, 1023, 0));
    pixel_queue.push_back(make_pixel(0, 0, 255, 1023, 1023, 1));
    pixel_queue.push_back(make_pixel(1, 1, 7, 300, 700, 1));
    drain();

    // top threshold: nothing can be red
    write_reg(THRESHOLD_ADDR, 32'd255);
    pixel_queue.push_back(make_pixel(0, 0, 255, 10, 10, 0));
    pixel_queue.push_back(make_pixel(0, 0, 255, 20, 20, 1));
    drain();

    // write to an unmapped register must leave the threshold alone
    write_reg(UNUSED_ADDR, 32'd0);
    pixel_queue.push_back(make_pixel(0, 0, 255, 1, 2, 1));
    drain();

    // largest ratio is 127: not red at 127, red at 126
    write_reg(THRESHOLD_ADDR, 32'd127);
    pixel_queue.push_back(make_pixel(0, 0, 255, 3, 3, 1));
    drain();
    write_reg(THRESHOLD_ADDR, 32'd126);
    pixel_queue.push_back(make_pixel(0, 0, 255, 3, 3, 1));
    drain();

    // random frames over a spread of thresholds
    write_reg(THRESHOLD_ADDR, 32'd0);
    random_frames(100, 12, 12);
    write_reg(THRESHOLD_ADDR, 32'd1);
    random_frames(100, 0, 0);
    write_reg(THRESHOLD_ADDR, {24'($urandom_range(0, 16777215)), 8'd255});
    random_frames(100, 12, 12);
    write_reg(THRESHOLD_ADDR, 32'd126);
    random_frames(100, 12, 12);
    write_reg(THRESHOLD_ADDR, {24'($urandom_range(0, 16777215)), 8'($urandom_range(0, 10))});
    random_frames(100, 12, 12);
    write_reg(THRESHOLD_ADDR, 32'd2);
    random_frames(100, 12, 12);
    write_reg(THRESHOLD_ADDR, 32'($urandom_range(0, 255)));
    random_frames(100, 12, 12);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
